FILE: rtl/core/tms_pkg.sv
package tms_pkg;

  localparam int NumSources = 4;
  localparam int FifoDepth  = 16;
  localparam int MaxResults = 64;
  localparam int SrcW  = $clog2(NumSources);
  localparam int PtrW  = $clog2(FifoDepth);
  localparam int CntW  = $clog2(FifoDepth + 1);
  localparam int AddrW = SrcW + PtrW;
  localparam int ResW  = $clog2(MaxResults + 1);

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_END    = 1'b1;

  localparam logic [1:0] DROP_NONE  = 2'd0;
  localparam logic [1:0] DROP_FULL  = 2'd1;
  localparam logic [1:0] DROP_ENDED = 2'd2;

  typedef struct packed {
    logic        op;
    logic [1:0]  source_index;
    logic [31:0] stamp_seconds;
    logic [29:0] stamp_nanos;
    logic [15:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic        packet_valid;
    logic [1:0]  out_source;
    logic [31:0] out_seconds;
    logic [29:0] out_nanos;
    logic [15:0] out_handle;
    logic        stream_done;
    logic [1:0]  drop_status;
    logic        last_result;
  } out_item_t;

  // Classified command passed from the front to the back part
  typedef struct packed {
    logic        drop;
    logic [1:0]  drop_code;
    logic [1:0]  src;
    logic [15:0] handle;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ,
    BK_EMIT,
    BK_LOAD,
    BK_DONE
  } back_state_t;

endpackage

FILE: rtl/core/tms_front.sv
module tms_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  tms_pkg::in_item_t  item,
  input  logic [2:0]         active_sources,
  input  logic [tms_pkg::NumSources-1:0] pop_src,
  output logic [tms_pkg::NumSources-1:0][tms_pkg::CntW-1:0] fill,
  output logic [tms_pkg::NumSources-1:0][tms_pkg::PtrW-1:0] rptr,
  output logic [tms_pkg::NumSources-1:0] ended,
  output logic               wr_en,
  output logic [tms_pkg::AddrW-1:0] wr_addr,
  output tms_pkg::cmd_t      cmd,
  output logic               cmd_push
);
  import tms_pkg::*;

  logic [NumSources-1:0][PtrW-1:0] wptr;
  logic [2:0] n_act;
  logic       in_range;
  logic       will_write;

  // Clamp active count to 1..NumSources
  always_comb begin
    n_act = active_sources;
    if (n_act == 3'd0) n_act = 3'd1;
    if ({1'b0, n_act} > 4'(NumSources)) n_act = 3'(NumSources);
  end

  assign in_range   = {1'b0, item.source_index} < n_act;
  assign will_write = take && in_range && item.op == OP_PACKET &&
                      !ended[item.source_index] &&
                      fill[item.source_index] < CntW'(FifoDepth);
  assign wr_en   = will_write;
  assign wr_addr = {item.source_index, wptr[item.source_index]};

  // Classify the item for the back part
  always_comb begin
    cmd.drop      = 1'b0;
    cmd.drop_code = DROP_NONE;
    cmd.src       = item.source_index;
    cmd.handle    = item.packet_handle;
    if (in_range && item.op == OP_PACKET) begin
      if (ended[item.source_index]) begin
        cmd.drop = 1'b1;
        cmd.drop_code = DROP_ENDED;
      end else if (fill[item.source_index] >= CntW'(FifoDepth)) begin
        cmd.drop = 1'b1;
        cmd.drop_code = DROP_FULL;
      end
    end
  end
  assign cmd_push = take;

  // Advance pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      fill  <= '0;
      ended <= '0;
    end else begin
      for (int i = 0; i < NumSources; i++) begin
        logic wi, pi;
        wi = will_write && item.source_index == SrcW'(i);
        pi = pop_src[i];
        if (wi) wptr[i] <= (wptr[i] == PtrW'(FifoDepth - 1)) ? '0 : wptr[i] + 1'b1;
        if (pi) rptr[i] <= (rptr[i] == PtrW'(FifoDepth - 1)) ? '0 : rptr[i] + 1'b1;
        if (wi && !pi) fill[i] <= fill[i] + 1'b1;
        else if (pi && !wi) fill[i] <= fill[i] - 1'b1;
      end
      if (take && in_range && item.op == OP_END) ended[item.source_index] <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/tms_back.sv
module tms_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  tms_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  input  logic [2:0]         active_sources,
  input  logic [tms_pkg::NumSources-1:0][tms_pkg::CntW-1:0] fill,
  input  logic [tms_pkg::NumSources-1:0][tms_pkg::PtrW-1:0] rptr,
  input  logic [tms_pkg::NumSources-1:0] ended,
  output logic [tms_pkg::NumSources-1:0] pop_src,
  output logic [tms_pkg::NumSources-1:0] head_load,
  output logic               rd_en,
  output logic [tms_pkg::AddrW-1:0] rd_addr,
  input  logic [31:0]        rd_sec,
  input  logic [29:0]        rd_ns,
  input  logic [15:0]        rd_hdl,
  input  logic               head_ok,
  input  logic [tms_pkg::NumSources-1:0][61:0] heads,
  output logic               strobe,
  output tms_pkg::out_item_t result,
  output logic               busy_back
);
  import tms_pkg::*;

  back_state_t state, state_next;
  logic        done_sent, done_sent_next;
  logic [ResW-1:0] count, count_next;
  logic [SrcW-1:0] best_src, best_src_next;
  logic [2:0]  n_act;
  logic        stall, any;
  logic [SrcW-1:0] best;
  logic [61:0] best_key;
  out_item_t   res_next;
  logic        strobe_next;
  out_item_t   hold, hold_next;
  logic        hold_valid, hold_valid_next;
  logic        at_limit;

  always_comb begin
    n_act = active_sources;
    if (n_act == 3'd0) n_act = 3'd1;
    if ({1'b0, n_act} > 4'(NumSources)) n_act = 3'(NumSources);
  end

  // Pick the smallest head; ties keep the lower index
  always_comb begin
    stall = 1'b0;
    any = 1'b0;
    best = '0;
    best_key = '0;
    for (int i = 0; i < NumSources; i++) begin
      if (4'(i) < {1'b0, n_act}) begin
        if (fill[i] == '0) begin
          if (!ended[i]) stall = 1'b1;
        end else if (!any || heads[i] < best_key) begin
          any = 1'b1;
          best = SrcW'(i);
          best_key = heads[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      done_sent  <= 1'b0;
      count      <= '0;
      strobe     <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      done_sent  <= done_sent_next;
      count      <= count_next;
      strobe     <= strobe_next;
      hold_valid <= hold_valid_next;
    end
    best_src <= best_src_next;
    result   <= res_next;
    hold     <= hold_next;
  end

  // Sequence drop, merge releases and completion for one item; each result
  // is held until the next decision so the final one can be marked
  always_comb begin
    state_next      = state;
    done_sent_next  = done_sent;
    count_next      = count;
    best_src_next   = best_src;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    res_next        = '0;
    strobe_next     = 1'b0;
    q_pop           = 1'b0;
    pop_src         = '0;
    head_load       = '0;
    rd_en           = 1'b0;
    rd_addr         = {best_src, rptr[best_src]};
    at_limit        = (count == ResW'(MaxResults));
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          count_next = '0;
          hold_next = '0;
          hold_valid_next = 1'b0;
          if (q_cmd.drop) begin
            hold_next.out_source  = q_cmd.src;
            hold_next.out_handle  = q_cmd.handle;
            hold_next.drop_status = q_cmd.drop_code;
            hold_valid_next = 1'b1;
            count_next = ResW'(1);
          end
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (at_limit || stall || !any) begin
          if (!at_limit && stall) done_sent_next = 1'b0;
          if (!at_limit && !stall && !any && !done_sent) begin
            if (hold_valid) begin
              // release the held result, completion follows
              res_next = hold;
              strobe_next = 1'b1;
              hold_valid_next = 1'b0;
              state_next = BK_DONE;
            end else begin
              res_next.stream_done = 1'b1;
              res_next.last_result = 1'b1;
              strobe_next = 1'b1;
              done_sent_next = 1'b1;
              state_next = BK_IDLE;
            end
          end else begin
            if (hold_valid) begin
              res_next = hold;
              res_next.last_result = 1'b1;
              strobe_next = 1'b1;
            end
            hold_valid_next = 1'b0;
            state_next = BK_IDLE;
          end
        end else begin
          if (hold_valid) begin
            res_next = hold;
            strobe_next = 1'b1;
          end
          hold_valid_next = 1'b0;
          best_src_next = best;
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        rd_en = 1'b1;
        pop_src[best_src] = 1'b1;
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        hold_next = '0;
        hold_next.packet_valid = 1'b1;
        hold_next.out_source   = best_src;
        hold_next.out_seconds  = rd_sec;
        hold_next.out_nanos    = rd_ns;
        hold_next.out_handle   = rd_hdl;
        hold_valid_next = 1'b1;
        count_next = count + 1'b1;
        // fetch the new head of the popped source
        if (fill[best_src] != '0) begin
          rd_en = 1'b1;
          state_next = BK_LOAD;
        end else begin
          state_next = BK_SCAN;
        end
      end
      BK_LOAD: begin
        head_load[best_src] = 1'b1;
        state_next = BK_SCAN;
      end
      BK_DONE: begin
        res_next.stream_done = 1'b1;
        res_next.last_result = 1'b1;
        strobe_next = 1'b1;
        done_sent_next = 1'b1;
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign busy_back = (state != BK_IDLE);

  a_pop_when_read: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pop_src)) else $error("more than one source popped");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == BK_READ) |-> fill[best_src] != '0) else $error("pop of empty fifo");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.stream_done) |-> $past(!done_sent)) else $error("double done");
  a_head_ok: assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT || state == BK_LOAD) |-> head_ok) else $error("read data missing");

endmodule

FILE: rtl/core/timestamp_merge_sorter_core.sv
// Channel  | Signals                          | Handshake
// input    | start, busy, in_item             | accepted when start && !busy
// result   | result_valid, result             | one cycle, no back pressure
// config   | cfg_valid, cfg_ready, cfg_data   | written when valid && ready
// An item passes through the one-entry command queue, then one head scan per
// decision; each forwarded packet costs scan, FIFO memory read with pop,
// result capture with head refetch, and head load (skipped when the source
// empties). A result leaves in the cycle after it is decided.
// Reset is synchronous and clears pointers, counts and end flags at once;
// FIFO storage is not cleared. Results cannot be stalled; busy drops in the
// cycle that carries an item's last result, if it has one.
module timestamp_merge_sorter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tms_pkg::in_item_t  in_item,
  output logic               result_valid,
  output tms_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);
  import tms_pkg::*;

  logic [2:0] active_sources;
  logic       take;
  logic [NumSources-1:0][CntW-1:0] fill;
  logic [NumSources-1:0][PtrW-1:0] rptr;
  logic [NumSources-1:0] ended, pop_src, head_load;
  logic       wr_en, rd_en, cmd_push, q_pop, q_valid, busy_back;
  logic [AddrW-1:0] wr_addr, rd_addr;
  cmd_t       cmd, q_cmd;
  logic [31:0] mem_sec [NumSources*FifoDepth];
  logic [29:0] mem_ns  [NumSources*FifoDepth];
  logic [15:0] mem_hdl [NumSources*FifoDepth];
  logic [31:0] rd_sec;
  logic [29:0] rd_ns;
  logic [15:0] rd_hdl;
  logic        head_ok;
  logic [NumSources-1:0][61:0] heads;

  // Hold off configuration while an item is offered or in flight
  assign cfg_ready = !busy && !start;
  always_ff @(posedge clk) begin
    if (rst) active_sources <= 3'd4;
    else if (cfg_valid && cfg_ready) active_sources <= cfg_data;
  end

  assign busy = q_valid || busy_back;
  assign take = start && !busy;

  // One-entry command queue between front and back
  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (cmd_push) q_valid <= 1'b1;
    else if (q_pop) q_valid <= 1'b0;
    if (cmd_push) q_cmd <= cmd;
  end

  // FIFO storage memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_sec[wr_addr] <= in_item.stamp_seconds;
      mem_ns[wr_addr]  <= in_item.stamp_nanos;
      mem_hdl[wr_addr] <= in_item.packet_handle;
    end
    if (rd_en) begin
      rd_sec <= mem_sec[rd_addr];
      rd_ns  <= mem_ns[rd_addr];
      rd_hdl <= mem_hdl[rd_addr];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) head_ok <= 1'b0;
    else head_ok <= rd_en;
  end

  // Head key registers: loaded on write of an empty fifo or from the
  // memory read that follows a pop, so the scan sees stable keys
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumSources; i++) begin
      if (head_load[i]) begin
        heads[i] <= {rd_sec, rd_ns};
      end else if (wr_en && wr_addr[AddrW-1:PtrW] == SrcW'(i) && fill[i] == '0) begin
        heads[i] <= {in_item.stamp_seconds, in_item.stamp_nanos};
      end
    end
  end

  tms_front u_front (
    .clk, .rst, .take, .item(in_item), .active_sources, .pop_src,
    .fill, .rptr, .ended, .wr_en, .wr_addr, .cmd, .cmd_push
  );

  tms_back u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .active_sources, .fill, .rptr,
    .ended, .pop_src, .head_load, .rd_en, .rd_addr, .rd_sec, .rd_ns, .rd_hdl,
    .head_ok, .heads, .strobe(result_valid), .result, .busy_back
  );

endmodule
